/* design/snos_pkg.sv */
package snos_pkg;

   // geometry
   localparam int DIMS        = 3;
   localparam int MAX_OCTAVES = 16;
   localparam int NCORN       = DIMS + 1;

   // configuration port
   localparam int CFG_W     = 32;
   localparam int PERS_W    = 16;
   localparam int OCT_W     = 5;
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_SCALE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PERSISTENCE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OCTAVES     = 3'd3;

   // datapath widths
   localparam int COORD_W = 32;
   localparam int P_W     = 48;
   localparam int SUM_W   = P_W + 3;
   localparam int LO_W    = 26;
   localparam int HI_W    = SUM_W - LO_W;
   localparam int FP_W    = SUM_W + 33;
   localparam int S_W     = FP_W - 32;
   localparam int PS_W    = S_W + 1;
   localparam int CELL_W  = PS_W - 32;
   localparam int CSUM_W  = CELL_W + 3;
   localparam int TG_W    = CSUM_W + 33;
   localparam int XF_W    = TG_W + 1;
   localparam int X_W     = 40;
   localparam int SQ_W    = 35;
   localparam int T_W     = 36;
   localparam int GRAD_W  = X_W + 3;
   localparam int GM_W    = 35;
   localparam int N_W     = GM_W + 3;
   localparam int NOISE_W = N_W + 5;
   localparam int AMP_W   = 17;
   localparam int WN_W    = NOISE_W + AMP_W + 1;
   localparam int CNT_W   = $clog2(MAX_OCTAVES + 1);
   localparam int TOT_W   = WN_W + CNT_W;
   localparam int AMP_SUM_W = $clog2(MAX_OCTAVES * 65536 + 1);

   // divider and result
   localparam int OUT_W = 18;
   localparam int QB    = OUT_W;
   localparam int NUM_W = TOT_W - 16;
   localparam int DIV_W = AMP_SUM_W + QB;
   localparam int DSH_W = DIV_W - 1;
   localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

   // constants
   localparam logic [31:0] SKEW_F = (DIMS == 2) ? 32'd1572067139 :
                                    (DIMS == 3) ? 32'd1431655765 : 32'd1327217885;
   localparam logic [31:0] UNSKEW_G = (DIMS == 2) ? 32'd907633386 :
                                      (DIMS == 3) ? 32'd715827883 : 32'd593549882;
   localparam logic signed [T_W-1:0] POINT_SIX = 36'sd2576980378;
   localparam logic [31:0] CUBE_MIX = 32'd60493;
   localparam logic [AMP_W-1:0] AMP_ONE = 17'd65536;
   localparam logic [X_W-1:0] X_ONE = X_W'(1) << 32;

   // pipeline depth
   localparam int OCT_STG = 15;
   localparam int LAT     = 1 + MAX_OCTAVES * OCT_STG + 1 + QB + 1;

   function automatic logic [31:0] prime_of(input int j);
      logic [31:0] r;
      case (j % 4)
         0:       r = 32'd1619;
         1:       r = 32'd31337;
         2:       r = 32'd6971;
         default: r = 32'd1013;
      endcase
      return r;
   endfunction

   typedef struct packed {
      logic                                valid;
      logic [DIMS-1:0][P_W-1:0]            p;
      logic [TOT_W-1:0]                    total;
      logic [AMP_SUM_W-1:0]                amp_sum;
      logic [AMP_W-1:0]                    amp;
      logic [CNT_W-1:0]                    k;
      logic [CNT_W-1:0]                    cnt;
   } oct_word_type;

   typedef struct packed {
      logic             valid;
      logic             neg;
      logic             ovf;
      logic [DIV_W-1:0] rem;
      logic [DSH_W-1:0] dsh;
      logic [QB-1:0]    q;
   } div_word_type;

endpackage

/* design/snos_oct_cell.sv */
module snos_oct_cell
   import snos_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [31:0]        seed,
   input  logic [PERS_W-1:0]  persistence,
   input  oct_word_type       in_w,
   output oct_word_type       out_w
);

   oct_word_type side_ff [OCT_STG-1];
   oct_word_type out_ff;

   // stage registers, named by stage number
   logic [LO_W+31:0]           plo_ff;
   logic signed [HI_W+32:0]    phi_ff;
   logic signed [CELL_W-1:0]   cell1_ff [DIMS];
   logic signed [TG_W-1:0]     tg2_ff;
   logic signed [CELL_W-1:0]   cell2_ff [DIMS];
   logic signed [X_W-1:0]      x3_ff [DIMS];
   logic signed [CELL_W-1:0]   cell3_ff [DIMS];
   logic signed [X_W-1:0]      x4_ff [DIMS];
   logic                       o4_ff [NCORN][DIMS];
   logic [31:0]                hc4_ff [NCORN][DIMS];
   logic signed [X_W-1:0]      v5_ff [NCORN][DIMS];
   logic [31:0]                m5_ff [NCORN][DIMS];
   logic                       near5_ff [NCORN];
   logic [31:0]                hp5_ff [NCORN][DIMS];
   logic signed [X_W-1:0]      v6_ff [NCORN][DIMS];
   logic [SQ_W-1:0]            sq6_ff [NCORN];
   logic                       near6_ff [NCORN];
   logic [31:0]                h6_ff [NCORN];
   logic signed [X_W-1:0]      v7_ff [NCORN][DIMS];
   logic [31:0]                t7_ff [NCORN];
   logic                       keep7_ff [NCORN];
   logic [31:0]                h7_ff [NCORN];
   logic [31:0]                h2_7_ff [NCORN];
   logic signed [X_W-1:0]      v8_ff [NCORN][DIMS];
   logic                       keep8_ff [NCORN];
   logic [31:0]                t2_8_ff [NCORN];
   logic [31:0]                h3_8_ff [NCORN];
   logic signed [X_W-1:0]      v9_ff [NCORN][DIMS];
   logic                       keep9_ff [NCORN];
   logic [31:0]                t4_9_ff [NCORN];
   logic [31:0]                h4_9_ff [NCORN];
   logic [GM_W-1:0]            gm10_ff [NCORN];
   logic                       gneg10_ff [NCORN];
   logic [31:0]                t4_10_ff [NCORN];
   logic [GM_W-1:0]            prod11_ff [NCORN];
   logic                       pneg11_ff [NCORN];
   logic signed [NOISE_W-1:0]  noise12_ff;
   logic signed [WN_W-1:0]     wn13_ff;
   logic [AMP_W-1:0]           ampn13_ff;

   // next values
   logic signed [SUM_W-1:0]    sum_in;
   logic [LO_W+31:0]           plo_in;
   logic signed [HI_W+32:0]    phi_in;
   logic signed [FP_W-1:0]     fp_in;
   logic signed [S_W-1:0]      s_in;
   logic signed [PS_W-1:0]     ps_in [DIMS];
   logic signed [CSUM_W-1:0]   csum_in;
   logic signed [TG_W-1:0]     tg_in;
   logic signed [XF_W-1:0]     xf_in [DIMS];
   logic [2:0]                 rank_in [DIMS];
   logic signed [X_W-1:0]      v_in [NCORN][DIMS];
   logic signed [X_W-1:0]      m_in [NCORN][DIMS];
   logic                       near_in [NCORN];
   logic [63:0]                mm_in [NCORN][DIMS];
   logic [SQ_W-1:0]            sq_in [NCORN];
   logic [31:0]                h_in [NCORN];
   logic signed [T_W-1:0]      t_in [NCORN];
   logic [63:0]                h2_in [NCORN];
   logic [63:0]                h3_in [NCORN];
   logic [63:0]                h4_in [NCORN];
   logic [63:0]                tt_in [NCORN];
   logic [63:0]                t4_in [NCORN];
   logic [3:0]                 hb_in [NCORN];
   logic signed [GRAD_W-1:0]   grad_in [NCORN];
   logic signed [GRAD_W-1:0]   gabs_in [NCORN];
   logic [31+GM_W:0]           pp_in [NCORN];
   logic signed [N_W-1:0]      n_in;
   logic signed [WN_W-1:0]     wn_in;
   logic [AMP_W+PERS_W-1:0]    ap_in;
   logic                       act_in;

   // skew sum, split into two partial products
   always_comb begin
      sum_in = '0;
      for (int j = 0; j < DIMS; j++) begin
         sum_in = sum_in + SUM_W'($signed(in_w.p[j]));
      end
      plo_in = sum_in[LO_W-1:0] * SKEW_F;
      phi_in = $signed(sum_in[SUM_W-1:LO_W]) * $signed({1'b0, SKEW_F});
   end

   // floor to lattice cell
   always_comb begin
      fp_in = (FP_W'(phi_ff) <<< LO_W) + FP_W'($signed({1'b0, plo_ff}));
      s_in  = fp_in[FP_W-1:32];
      for (int j = 0; j < DIMS; j++) begin
         ps_in[j] = PS_W'($signed(side_ff[0].p[j])) + PS_W'(s_in);
      end
   end

   // unskew
   always_comb begin
      csum_in = '0;
      for (int j = 0; j < DIMS; j++) begin
         csum_in = csum_in + CSUM_W'(cell1_ff[j]);
      end
      tg_in = $signed(csum_in) * $signed({1'b0, UNSKEW_G});
      for (int j = 0; j < DIMS; j++) begin
         xf_in[j] = XF_W'($signed(side_ff[2].p[j])) - (XF_W'(cell2_ff[j]) <<< 32)
                    + XF_W'(tg2_ff);
      end
   end

   // rank offsets; ties give the later axis the higher rank
   always_comb begin
      for (int j = 0; j < DIMS; j++) begin
         rank_in[j] = '0;
      end
      for (int i = 0; i < DIMS; i++) begin
         for (int j = i + 1; j < DIMS; j++) begin
            if (x3_ff[i] > x3_ff[j]) begin
               rank_in[i] = rank_in[i] + 3'd1;
            end else begin
               rank_in[j] = rank_in[j] + 3'd1;
            end
         end
      end
   end

   // corner offsets and distance
   always_comb begin
      for (int c = 0; c < NCORN; c++) begin
         near_in[c] = 1'b1;
         for (int j = 0; j < DIMS; j++) begin
            v_in[c][j] = x4_ff[j] - (o4_ff[c][j] ? X_ONE : '0)
                         + X_W'(c) * X_W'(UNSKEW_G);
            m_in[c][j] = v_in[c][j][X_W-1] ? -v_in[c][j] : v_in[c][j];
            if (m_in[c][j][X_W-1:32] != '0) begin
               near_in[c] = 1'b0;
            end
         end
      end
   end

   // squared distance and corner hash
   always_comb begin
      for (int c = 0; c < NCORN; c++) begin
         sq_in[c] = '0;
         h_in[c]  = seed;
         for (int j = 0; j < DIMS; j++) begin
            mm_in[c][j] = 64'(m5_ff[c][j]) * 64'(m5_ff[c][j]);
            sq_in[c] = sq_in[c] + SQ_W'(mm_in[c][j][63:32]);
            h_in[c]  = h_in[c] ^ hp5_ff[c][j];
         end
      end
   end

   // falloff and hash mix
   always_comb begin
      for (int c = 0; c < NCORN; c++) begin
         t_in[c]  = POINT_SIX - $signed({1'b0, sq6_ff[c]});
         h2_in[c] = 64'(h6_ff[c]) * 64'(h6_ff[c]);
         h3_in[c] = 64'(h2_7_ff[c]) * 64'(h7_ff[c]);
         tt_in[c] = 64'(t7_ff[c]) * 64'(t7_ff[c]);
         h4_in[c] = 64'(h3_8_ff[c]) * 64'(CUBE_MIX);
         t4_in[c] = 64'(t2_8_ff[c]) * 64'(t2_8_ff[c]);
      end
   end

   // gradient from hash bits
   always_comb begin
      for (int c = 0; c < NCORN; c++) begin
         hb_in[c]   = h4_9_ff[c][16:13] ^ h4_9_ff[c][3:0];
         grad_in[c] = '0;
         for (int j = 0; j < DIMS; j++) begin
            if (hb_in[c][DIMS-1-j]) begin
               grad_in[c] = grad_in[c] + GRAD_W'(v9_ff[c][j]);
            end else begin
               grad_in[c] = grad_in[c] - GRAD_W'(v9_ff[c][j]);
            end
         end
         gabs_in[c] = grad_in[c][GRAD_W-1] ? -grad_in[c] : grad_in[c];
         pp_in[c]   = (32+GM_W)'(t4_10_ff[c]) * (32+GM_W)'(gm10_ff[c]);
      end
   end

   // corner sum, weight and accumulate
   always_comb begin
      n_in = '0;
      for (int c = 0; c < NCORN; c++) begin
         if (pneg11_ff[c]) begin
            n_in = n_in - N_W'(prod11_ff[c]);
         end else begin
            n_in = n_in + N_W'(prod11_ff[c]);
         end
      end
      wn_in  = $signed(noise12_ff) * $signed({1'b0, side_ff[12].amp});
      ap_in  = side_ff[12].amp * persistence;
      act_in = side_ff[OCT_STG-2].k < side_ff[OCT_STG-2].cnt;
   end

   // side word delay line; valid is the only control bit
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < OCT_STG - 1; i++) begin
            side_ff[i].valid <= 1'b0;
         end
         out_ff.valid <= 1'b0;
      end else begin
         side_ff[0] <= in_w;
         for (int i = 1; i < OCT_STG - 1; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         out_ff.valid <= side_ff[OCT_STG-2].valid;
         out_ff.cnt   <= side_ff[OCT_STG-2].cnt;
         for (int j = 0; j < DIMS; j++) begin
            out_ff.p[j] <= {side_ff[OCT_STG-2].p[j][P_W-2:0], 1'b0};
         end
         out_ff.total   <= side_ff[OCT_STG-2].total + (act_in ? TOT_W'(wn13_ff) : '0);
         out_ff.amp_sum <= side_ff[OCT_STG-2].amp_sum
                           + (act_in ? AMP_SUM_W'(side_ff[OCT_STG-2].amp) : '0);
         out_ff.amp     <= ampn13_ff;
         out_ff.k       <= side_ff[OCT_STG-2].k + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      plo_ff <= plo_in;
      phi_ff <= phi_in;
      tg2_ff <= tg_in;
      for (int j = 0; j < DIMS; j++) begin
         cell1_ff[j] <= ps_in[j][PS_W-1:32];
         cell2_ff[j] <= cell1_ff[j];
         x3_ff[j]    <= xf_in[j][X_W-1:0];
         cell3_ff[j] <= cell2_ff[j];
         x4_ff[j]    <= x3_ff[j];
      end
      for (int c = 0; c < NCORN; c++) begin
         for (int j = 0; j < DIMS; j++) begin
            o4_ff[c][j]  <= (int'(rank_in[j]) + c >= DIMS);
            hc4_ff[c][j] <= 32'(cell3_ff[j]) + ((int'(rank_in[j]) + c >= DIMS) ? 32'd1 : 32'd0);
            v5_ff[c][j]  <= v_in[c][j];
            m5_ff[c][j]  <= m_in[c][j][31:0];
            hp5_ff[c][j] <= prime_of(j) * hc4_ff[c][j];
            v6_ff[c][j]  <= v5_ff[c][j];
            v7_ff[c][j]  <= v6_ff[c][j];
            v8_ff[c][j]  <= v7_ff[c][j];
            v9_ff[c][j]  <= v8_ff[c][j];
         end
         near5_ff[c]  <= near_in[c];
         sq6_ff[c]    <= sq_in[c];
         near6_ff[c]  <= near5_ff[c];
         h6_ff[c]     <= h_in[c];
         t7_ff[c]     <= t_in[c][31:0];
         keep7_ff[c]  <= near6_ff[c] & ~t_in[c][T_W-1];
         h7_ff[c]     <= h6_ff[c];
         h2_7_ff[c]   <= h2_in[c][31:0];
         keep8_ff[c]  <= keep7_ff[c];
         t2_8_ff[c]   <= tt_in[c][63:32];
         h3_8_ff[c]   <= h3_in[c][31:0];
         keep9_ff[c]  <= keep8_ff[c];
         t4_9_ff[c]   <= t4_in[c][63:32];
         h4_9_ff[c]   <= h4_in[c][31:0];
         gm10_ff[c]   <= keep9_ff[c] ? gabs_in[c][GM_W-1:0] : '0;
         gneg10_ff[c] <= grad_in[c][GRAD_W-1];
         t4_10_ff[c]  <= t4_9_ff[c];
         prod11_ff[c] <= pp_in[c][31+GM_W:32];
         pneg11_ff[c] <= gneg10_ff[c];
      end
      noise12_ff <= NOISE_W'(n_in) <<< 5;
      wn13_ff    <= wn_in;
      ampn13_ff  <= ap_in[AMP_W+PERS_W-1:PERS_W];
   end

   assign out_w = out_ff;

endmodule

/* design/snos_div_cell.sv */
module snos_div_cell
   import snos_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  div_word_type in_w,
   output div_word_type out_w
);

   div_word_type out_ff;
   logic         ge_in;

   // one quotient bit: subtract the shifted divisor where it fits
   assign ge_in = in_w.rem >= DIV_W'(in_w.dsh);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else begin
         out_ff.valid <= in_w.valid;
      end
      out_ff.neg   <= in_w.neg;
      out_ff.ovf   <= in_w.ovf;
      out_ff.rem   <= ge_in ? in_w.rem - DIV_W'(in_w.dsh) : in_w.rem;
      out_ff.dsh   <= in_w.dsh >> 1;
      out_ff.q     <= {in_w.q[QB-2:0], ge_in};
   end

   assign out_w = out_ff;

endmodule

/* design/simplex_noise_octave_sum_top.sv */
// Fractal 3-D simplex noise. Raise start with a Q16.16 point on req_coord_x/y/z;
// it is taken at any clock edge where busy is low, and busy is only high while
// reset is asserted, so a new point may follow every cycle. Each point returns
// one word on rsp_noise_value (signed Q1.16, saturated to [-2,2)) marked by a
// one-cycle rsp_valid strobe, in the order the points were taken. There is no way to hold a result off:
// capture it in the strobe cycle. A point passes the front register, the octave
// chain (one cell per possible octave, 15 stages each, all cells traversed
// whatever the octave count), the divider set-up register, the 18-cell
// bit-per-stage normalizing divider and the output register. Write the
// registers through csr_we/csr_index/csr_wdata only while no point is in flight:
// index 0 seed, 1 base_scale (Q16.16), 2 persistence (Q0.16), 3 octaves.
module simplex_noise_octave_sum_top
   import snos_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [COORD_W-1:0] req_coord_x,
   input  logic signed [COORD_W-1:0] req_coord_y,
   input  logic signed [COORD_W-1:0] req_coord_z,
   output logic                      rsp_valid,
   output logic signed [OUT_W-1:0]   rsp_noise_value,
   input  logic                      csr_we,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CFG_W-1:0]          csr_wdata
);

   logic [31:0]         seed_ff;
   logic [31:0]         scale_ff;
   logic [PERS_W-1:0]   pers_ff;
   logic [OCT_W-1:0]    oct_ff;

   logic                accept;
   logic [CNT_W-1:0]    cnt_in;
   logic signed [COORD_W-1:0] coord_in [DIMS];
   logic signed [2*COORD_W:0] sp_in [DIMS];
   oct_word_type        front_in;
   oct_word_type        front_ff;
   oct_word_type        link [MAX_OCTAVES+1];

   logic [TOT_W-1:0]    mag_in;
   logic [NUM_W-1:0]    num_in;
   div_word_type        pre_in;
   div_word_type        pre_ff;
   div_word_type        dlink [QB+1];

   logic                rsp_valid_ff;
   logic [OUT_W-1:0]    rsp_value_ff;
   logic [OUT_W-1:0]    value_in;

   // the block is ready every cycle outside reset
   assign busy   = reset;
   assign accept = start & ~busy;

   // register file; writes are to happen only while idle, a rule for the user that the block does not enforce
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff  <= '0;
         scale_ff <= 32'd65536;
         pers_ff  <= 16'd32768;
         oct_ff   <= 5'd1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SEED:        seed_ff  <= csr_wdata[31:0];
            CSR_BASE_SCALE:  scale_ff <= csr_wdata[31:0];
            CSR_PERSISTENCE: pers_ff  <= csr_wdata[PERS_W-1:0];
            CSR_OCTAVES:     oct_ff   <= csr_wdata[OCT_W-1:0];
            default:         ;
         endcase
      end
   end

   // zero octaves run one; clamp at the chain length
   always_comb begin
      if (oct_ff == '0) begin
         cnt_in = CNT_W'(1);
      end else if (int'(oct_ff) > MAX_OCTAVES) begin
         cnt_in = CNT_W'(MAX_OCTAVES);
      end else begin
         cnt_in = CNT_W'(oct_ff);
      end
   end

   // scale the point into Q16.32, kept modulo 2^48; later octaves double it
   always_comb begin
      front_in = '0;
      for (int j = 0; j < DIMS; j++) begin
         case (j)
            0:       coord_in[j] = req_coord_x;
            1:       coord_in[j] = req_coord_y;
            2:       coord_in[j] = req_coord_z;
            default: coord_in[j] = '0;
         endcase
         sp_in[j] = coord_in[j] * $signed({1'b0, scale_ff});
         front_in.p[j] = sp_in[j][P_W-1:0];
      end
      front_in.valid   = accept;
      front_in.total   = '0;
      front_in.amp_sum = '0;
      front_in.amp     = AMP_ONE;
      front_in.k       = '0;
      front_in.cnt     = cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
      end else begin
         front_ff <= front_in;
      end
   end

   assign link[0] = front_ff;

   // one cell per octave; each hands its word on every cycle
   for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_oct
      snos_oct_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .seed        (seed_ff),
         .persistence (pers_ff),
         .in_w        (link[g]),
         .out_w       (link[g+1])
      );
   end

   // divide by amp_sum * 2^16: drop the 16 bits first, flag overflow up front
   always_comb begin
      mag_in = link[MAX_OCTAVES].total[TOT_W-1] ? -link[MAX_OCTAVES].total
                                                : link[MAX_OCTAVES].total;
      num_in = mag_in[TOT_W-1:16];
      pre_in.valid = link[MAX_OCTAVES].valid;
      pre_in.neg   = link[MAX_OCTAVES].total[TOT_W-1];
      pre_in.ovf   = num_in >= NUM_W'({link[MAX_OCTAVES].amp_sum, {QB{1'b0}}});
      pre_in.rem   = num_in[DIV_W-1:0];
      pre_in.dsh   = {link[MAX_OCTAVES].amp_sum, {(QB-1){1'b0}}};
      pre_in.q     = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_ff <= '0;
      end else begin
         pre_ff <= pre_in;
      end
   end

   assign dlink[0] = pre_ff;

   for (genvar g = 0; g < QB; g++) begin : g_div
      snos_div_cell u_div (
         .clock (clock),
         .reset (reset),
         .in_w  (dlink[g]),
         .out_w (dlink[g+1])
      );
   end

   // restore the sign and saturate
   always_comb begin
      if (!dlink[QB].neg) begin
         value_in = (dlink[QB].ovf || dlink[QB].q > OUT_MAX) ? OUT_MAX : dlink[QB].q;
      end else begin
         value_in = (dlink[QB].ovf || dlink[QB].q > OUT_MIN) ? OUT_MIN : -dlink[QB].q;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= value_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dlink[QB].valid;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_value_ff;

endmodule

/* design/snos_checker.sv */
module snos_checker
   import snos_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // every taken point comes back after the fixed latency
   a_lat_fwd: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("taken point did not return after fixed latency");

   // no word appears without a point taken the fixed latency before
   a_lat_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result word without matching point");

   // reset flushes the pipeline
   a_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word right after reset");

endmodule

bind simplex_noise_octave_sum_top snos_checker u_snos_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);
